### design/ehrl_pkg.sv
`timescale 1ns / 1ps
package ehrl_pkg;

  localparam int unsigned TEXT_SIZE   = 4096;
  localparam int unsigned MAX_RECORDS = 64;
  localparam int unsigned TXT_AW      = $clog2(TEXT_SIZE);
  localparam int unsigned TXT_CW      = TXT_AW + 1;
  localparam int unsigned REC_AW      = $clog2(MAX_RECORDS);
  localparam int unsigned REC_CW      = REC_AW + 1;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned META_W      = 1 + LEN_W + TXT_AW;
  localparam int unsigned PLACE_W     = 40;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_DEL_BYTE  = 3'd1,
    OP_READ_REC  = 3'd2,
    OP_READ_TEXT = 3'd3,
    OP_CLEAR     = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_REFUSED = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MAKE,
    S_EVICT,
    S_LOG,
    S_BYTE,
    S_RD_META,
    S_RD_TEXT,
    S_RESP
  } seq_state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        first;
    logic [23:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic [5:0]  record_index;
    logic [11:0] byte_offset;
    logic [15:0] limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        rec_kind;
    logic [23:0] rec_line;
    logic [15:0] rec_column;
    logic [15:0] rec_length;
    logic [11:0] rec_text_pos;
    logic [7:0]  read_byte;
    logic [6:0]  record_count;
    logic [12:0] text_used;
  } out_item_t;

  typedef struct packed {
    logic              clear;
    logic              evict;
    logic              evict_del;
    logic [LEN_W-1:0]  evict_len;
    logic              push_rec;
    logic              add_text;
    logic [TXT_CW-1:0] add_len;
  } ring_cmd_t;

  typedef struct packed {
    logic [TXT_AW-1:0] text_head;
    logic [TXT_CW-1:0] text_fill;
    logic [REC_AW-1:0] rec_head;
    logic [REC_CW-1:0] rec_fill;
  } ring_state_t;

endpackage

### design/edit_history_ring_log_unit.sv
`timescale 1ns / 1ps
// Channel   Signals                            Moves
// in        in_valid_i / in_ready_o / in_data_i    one edit or read transaction
// out       out_valid_o / out_ready_i / out_data_o one result transaction
// cfg       cfg_we_i / cfg_wdata_i                 recording_enabled write
//
// After idle and decode, an insert makes room, then logs; a delete byte
// writes its byte, the first after making room; a read fetches meta, and a
// text read then a byte; the eviction loop shares one meta RAM read port.
// Reset clears ring pointers, fills and pending deletion; RAMs need no clear.
// Input is taken only in idle; a result waiting on out_ready_i holds the
// sequencer in its response step while the previous result drains.
module edit_history_ring_log_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ehrl_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ehrl_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);
  import ehrl_pkg::*;

  seq_state_e  state_q, state_d;
  in_item_t    item_q, item_d;
  out_item_t   res_q, res_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        rec_en_q;

  logic              delete_active_q, delete_active_d;
  logic [TXT_CW-1:0] bytes_pending_q, bytes_pending_d;
  logic [23:0]       pending_line_q, pending_line_d;
  logic [15:0]       pending_column_q, pending_column_d;
  logic [TXT_CW-1:0] pending_length_q, pending_length_d;
  logic [TXT_AW-1:0] pending_pos_q, pending_pos_d;

  ring_cmd_t   ring_cmd;
  ring_state_t ring;

  logic               is_read;
  logic [REC_AW-1:0]  rd_slot;
  logic [REC_AW-1:0]  wr_slot;
  logic               meta_we;
  logic [REC_AW-1:0]  meta_raddr;
  logic [META_W-1:0]  meta_wdata, meta_rdata;
  logic [PLACE_W-1:0] place_wdata, place_rdata;
  logic               text_we;
  logic [TXT_AW-1:0]  text_waddr, text_raddr;
  logic [7:0]         text_rdata;
  logic               m_kind;
  logic [LEN_W-1:0]   m_len;
  logic [TXT_AW-1:0]  m_pos;
  logic               ok_text;
  logic [TXT_CW-1:0]  need;
  logic [TXT_CW-1:0]  free;
  logic               evict_cond;
  logic               last_byte;

  assign is_read = (item_q.opcode == OP_READ_REC) || (item_q.opcode == OP_READ_TEXT);
  assign rd_slot = ring.rec_head + REC_AW'(item_q.record_index);
  assign wr_slot = ring.rec_head + ring.rec_fill[REC_AW-1:0];
  assign meta_raddr = is_read ? rd_slot : ring.rec_head;

  assign m_kind = meta_rdata[0];
  assign m_len  = meta_rdata[LEN_W:1];
  assign m_pos  = meta_rdata[META_W-1:LEN_W+1];
  assign ok_text = m_kind && (m_len <= item_q.limit) &&
                   (LEN_W'(item_q.byte_offset) < m_len);
  assign text_raddr = m_pos + TXT_AW'(item_q.byte_offset);

  assign need = (item_q.opcode == OP_INSERT) ? '0 : TXT_CW'(item_q.length);
  assign free = TXT_CW'(TEXT_SIZE) - ring.text_fill;
  assign evict_cond = ((ring.rec_fill != '0) && (free < need)) ||
                      (ring.rec_fill >= REC_CW'(MAX_RECORDS));
  assign last_byte = (bytes_pending_q == TXT_CW'(1));

  assign text_we    = (state_q == S_BYTE);
  assign text_waddr = pending_pos_q + pending_length_q[TXT_AW-1:0] -
                      bytes_pending_q[TXT_AW-1:0];
  assign meta_we    = (state_q == S_LOG) || ((state_q == S_BYTE) && last_byte);

  always_comb begin
    if (state_q == S_LOG) begin
      meta_wdata  = {TXT_AW'(0), item_q.length, 1'b0};
      place_wdata = {item_q.line, item_q.column};
    end else begin
      meta_wdata  = {pending_pos_q, LEN_W'(pending_length_q), 1'b1};
      place_wdata = {pending_line_q, pending_column_q};
    end
  end

  ehrl_ram #(.WIDTH(META_W), .DEPTH(MAX_RECORDS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (wr_slot),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  ehrl_ram #(.WIDTH(PLACE_W), .DEPTH(MAX_RECORDS)) u_place_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (wr_slot),
    .wdata_i (place_wdata),
    .raddr_i (rd_slot),
    .rdata_o (place_rdata)
  );

  ehrl_ram #(.WIDTH(8), .DEPTH(TEXT_SIZE)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (text_waddr),
    .wdata_i (item_q.data_byte),
    .raddr_i (text_raddr),
    .rdata_o (text_rdata)
  );

  ehrl_ring_ctl u_ring_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ring_cmd),
    .ring_o (ring)
  );

  always_comb begin
    state_d          = state_q;
    item_d           = item_q;
    res_d            = res_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q;
    delete_active_d  = delete_active_q;
    bytes_pending_d  = bytes_pending_q;
    pending_line_d   = pending_line_q;
    pending_column_d = pending_column_q;
    pending_length_d = pending_length_q;
    pending_pos_d    = pending_pos_q;
    ring_cmd         = '0;
    in_ready_o       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d       = in_data_i;
          res_d        = '0;
          res_d.status = ST_IGNORED;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESP;
        case (opcode_e'(item_q.opcode))
          OP_INSERT: begin
            if (rec_en_q && (item_q.length != '0)) begin
              delete_active_d = 1'b0;
              bytes_pending_d = '0;
              state_d         = S_MAKE;
            end
          end
          OP_DEL_BYTE: begin
            if (rec_en_q) begin
              if (item_q.first) begin
                if (item_q.length == '0) begin
                  if (delete_active_q) begin
                    state_d = S_BYTE;
                  end
                end else if (item_q.length > LEN_W'(TEXT_SIZE)) begin
                  ring_cmd.clear  = 1'b1;
                  delete_active_d = 1'b0;
                  bytes_pending_d = '0;
                  res_d.status    = ST_CLEARED;
                end else begin
                  state_d = S_MAKE;
                end
              end else if (delete_active_q) begin
                state_d = S_BYTE;
              end
            end
          end
          OP_READ_REC, OP_READ_TEXT: begin
            if (REC_CW'(item_q.record_index) < ring.rec_fill) begin
              state_d = S_RD_META;
            end else begin
              res_d.status = ST_REFUSED;
            end
          end
          OP_CLEAR: begin
            ring_cmd.clear  = 1'b1;
            delete_active_d = 1'b0;
            bytes_pending_d = '0;
            res_d.status    = ST_DONE;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_MAKE: begin
        if (evict_cond) begin
          state_d = S_EVICT;
        end else if (item_q.opcode == OP_INSERT) begin
          state_d = S_LOG;
        end else begin
          delete_active_d  = 1'b1;
          bytes_pending_d  = TXT_CW'(item_q.length);
          pending_length_d = TXT_CW'(item_q.length);
          pending_line_d   = item_q.line;
          pending_column_d = item_q.column;
          pending_pos_d    = ring.text_head + ring.text_fill[TXT_AW-1:0];
          state_d          = S_BYTE;
        end
      end
      S_EVICT: begin
        ring_cmd.evict     = 1'b1;
        ring_cmd.evict_del = m_kind;
        ring_cmd.evict_len = m_len;
        state_d            = S_MAKE;
      end
      S_LOG: begin
        ring_cmd.push_rec = 1'b1;
        res_d.status      = ST_DONE;
        state_d           = S_RESP;
      end
      S_BYTE: begin
        bytes_pending_d = bytes_pending_q - TXT_CW'(1);
        if (last_byte) begin
          ring_cmd.push_rec = 1'b1;
          ring_cmd.add_text = 1'b1;
          ring_cmd.add_len  = pending_length_q;
          delete_active_d   = 1'b0;
        end
        res_d.status = ST_DONE;
        state_d      = S_RESP;
      end
      S_RD_META: begin
        state_d = S_RESP;
        if ((item_q.opcode == OP_READ_REC) || ok_text) begin
          res_d.status       = ST_DONE;
          res_d.rec_kind     = m_kind;
          res_d.rec_length   = m_len;
          res_d.rec_text_pos = m_pos;
          res_d.rec_line     = place_rdata[PLACE_W-1:16];
          res_d.rec_column   = place_rdata[15:0];
          if (item_q.opcode == OP_READ_TEXT) begin
            state_d = S_RD_TEXT;
          end
        end else begin
          res_d.status = ST_REFUSED;
        end
      end
      S_RD_TEXT: begin
        res_d.read_byte = text_rdata;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d              = res_q;
          out_d.record_count = ring.rec_fill;
          out_d.text_used    = ring.text_fill;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      out_valid_q     <= 1'b0;
      rec_en_q        <= 1'b1;
      delete_active_q <= 1'b0;
      bytes_pending_q <= '0;
    end else begin
      state_q         <= state_d;
      out_valid_q     <= out_valid_d;
      delete_active_q <= delete_active_d;
      bytes_pending_q <= bytes_pending_d;
      if (cfg_we_i) begin
        rec_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q           <= item_d;
    res_q            <= res_d;
    out_q            <= out_d;
    pending_line_q   <= pending_line_d;
    pending_column_q <= pending_column_d;
    pending_length_q <= pending_length_d;
    pending_pos_q    <= pending_pos_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/ehrl_ram.sv
`timescale 1ns / 1ps
module ehrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ehrl_ring_ctl.sv
`timescale 1ns / 1ps
module ehrl_ring_ctl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ehrl_pkg::ring_cmd_t     cmd_i,
  output ehrl_pkg::ring_state_t   ring_o
);
  import ehrl_pkg::*;

  logic [TXT_AW-1:0] text_head_q, text_head_d;
  logic [TXT_CW-1:0] text_fill_q, text_fill_d;
  logic [REC_AW-1:0] rec_head_q, rec_head_d;
  logic [REC_CW-1:0] rec_fill_q, rec_fill_d;

  always_comb begin
    text_head_d = text_head_q;
    text_fill_d = text_fill_q;
    rec_head_d  = rec_head_q;
    rec_fill_d  = rec_fill_q;
    if (cmd_i.clear) begin
      text_head_d = '0;
      text_fill_d = '0;
      rec_head_d  = '0;
      rec_fill_d  = '0;
    end else begin
      if (cmd_i.evict) begin
        if (cmd_i.evict_del) begin
          text_head_d = text_head_q + cmd_i.evict_len[TXT_AW-1:0];
          if (LEN_W'(text_fill_q) >= cmd_i.evict_len) begin
            text_fill_d = text_fill_q - TXT_CW'(cmd_i.evict_len);
          end else begin
            text_fill_d = '0;
          end
        end
        rec_head_d = rec_head_q + REC_AW'(1);
        rec_fill_d = rec_fill_q - REC_CW'(1);
      end
      if (cmd_i.push_rec) begin
        rec_fill_d = rec_fill_q + REC_CW'(1);
      end
      if (cmd_i.add_text) begin
        text_fill_d = text_fill_q + cmd_i.add_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_head_q <= '0;
      text_fill_q <= '0;
      rec_head_q  <= '0;
      rec_fill_q  <= '0;
    end else begin
      text_head_q <= text_head_d;
      text_fill_q <= text_fill_d;
      rec_head_q  <= rec_head_d;
      rec_fill_q  <= rec_fill_d;
    end
  end

  assign ring_o.text_head = text_head_q;
  assign ring_o.text_fill = text_fill_q;
  assign ring_o.rec_head  = rec_head_q;
  assign ring_o.rec_fill  = rec_fill_q;

endmodule

### tb/edit_history_ring_log_unit_tb.sv
`timescale 1ns / 1ps
module edit_history_ring_log_unit_tb;
  import ehrl_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [2:0]  OP_RSVD_LO   = 3'd5;
  localparam logic [2:0]  OP_RSVD_HI   = 3'd7;
  localparam bit [5:0]    PHASE_REC_ON = 6'b101101;
  localparam bit [5:0]    PHASE_IDLE   = 6'b011011;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;
  logic      cfg_we_i;
  logic      cfg_wdata_i;

  // predicted log contents
  logic [7:0]  deleted_text [TEXT_SIZE];
  bit          kind_at [MAX_RECORDS];
  bit [15:0]   len_at  [MAX_RECORDS];
  bit [11:0]   pos_at  [MAX_RECORDS];
  bit [23:0]   line_at [MAX_RECORDS];
  bit [15:0]   col_at  [MAX_RECORDS];
  int unsigned text_head = 0;
  int unsigned text_fill = 0;
  int unsigned rec_head = 0;
  int unsigned rec_fill = 0;
  bit          del_busy = 0;
  int unsigned bytes_left = 0;
  int unsigned pend_line = 0;
  int unsigned pend_col = 0;
  int unsigned pend_len = 0;
  int unsigned pend_pos = 0;
  bit          rec_on = 1;

  out_item_t   result_q [$];
  out_item_t   want_res;
  dir_row_t    dir_rows [$];
  int unsigned phase_items [6] = '{220, 80, 180, 160, 60, 140};
  int          del_left = 0;
  bit          idle_on = 1;
  bit          long_hold_req = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_fail = 0;
  int unsigned n_cfg = 0;
  int unsigned cycles = 0;

  edit_history_ring_log_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_log();
    text_head = 0;
    text_fill = 0;
    rec_head = 0;
    rec_fill = 0;
    del_busy = 0;
    bytes_left = 0;
  endfunction

  function automatic void evict_head();
    int unsigned s;
    if (rec_fill == 0) return;
    s = rec_head;
    if (kind_at[s]) begin
      text_head = (text_head + len_at[s]) % TEXT_SIZE;
      text_fill = (text_fill >= len_at[s]) ? text_fill - len_at[s] : 0;
    end
    rec_head = (rec_head + 1) % MAX_RECORDS;
    rec_fill--;
  endfunction

  function automatic void reserve_space(input int unsigned need);
    while (rec_fill > 0 && TEXT_SIZE - text_fill < need) evict_head();
    while (rec_fill >= MAX_RECORDS) evict_head();
  endfunction

  function automatic void push_record(input bit kind, input int unsigned ln,
                                      input int unsigned col, input int unsigned len,
                                      input int unsigned pos);
    int unsigned s;
    s = (rec_head + rec_fill) % MAX_RECORDS;
    kind_at[s] = kind;
    len_at[s] = len[15:0];
    pos_at[s] = pos[11:0];
    line_at[s] = ln[23:0];
    col_at[s] = col[15:0];
    rec_fill++;
  endfunction

  function automatic out_item_t log_edit(input in_item_t it);
    out_item_t   r;
    int unsigned len;
    int unsigned s;
    int unsigned at;
    bit          ok;
    r = '0;
    r.status = ST_IGNORED;
    len = it.length;
    case (it.opcode)
      OP_INSERT: begin
        if (rec_on && len != 0) begin
          del_busy = 0;
          bytes_left = 0;
          reserve_space(0);
          push_record(1'b0, it.line, it.column, len, 0);
          r.status = ST_DONE;
        end
      end
      OP_DEL_BYTE: begin
        if (rec_on) begin
          if (it.first && len > TEXT_SIZE) begin
            clear_log();
            r.status = ST_CLEARED;
          end else if (it.first && len != 0) begin
            reserve_space(len);
            del_busy = 1;
            bytes_left = len;
            pend_len = len;
            pend_line = it.line;
            pend_col = it.column;
            pend_pos = (text_head + text_fill) % TEXT_SIZE;
          end
          if (del_busy && r.status != ST_CLEARED && bytes_left != 0) begin
            at = (pend_pos + (pend_len - bytes_left)) % TEXT_SIZE;
            deleted_text[at] = it.data_byte;
            bytes_left--;
            if (bytes_left == 0) begin
              text_fill += pend_len;
              push_record(1'b1, pend_line, pend_col, pend_len, pend_pos);
              del_busy = 0;
            end
            r.status = ST_DONE;
          end
        end
      end
      OP_READ_REC, OP_READ_TEXT: begin
        r.status = ST_REFUSED;
        if (it.record_index < rec_fill) begin
          s = (rec_head + it.record_index) % MAX_RECORDS;
          ok = (it.opcode == OP_READ_REC) ||
               (kind_at[s] && len_at[s] <= it.limit && it.byte_offset < len_at[s]);
          if (ok) begin
            r.status = ST_DONE;
            r.rec_kind = kind_at[s];
            r.rec_line = line_at[s];
            r.rec_column = col_at[s];
            r.rec_length = len_at[s];
            r.rec_text_pos = pos_at[s];
            if (it.opcode == OP_READ_TEXT)
              r.read_byte = deleted_text[(pos_at[s] + it.byte_offset) % TEXT_SIZE];
          end
        end
      end
      OP_CLEAR: begin
        clear_log();
        r.status = ST_DONE;
      end
      default: ;
    endcase
    r.record_count = rec_fill[6:0];
    r.text_used = text_fill[12:0];
    return r;
  endfunction

  function automatic in_item_t mk_in(input logic [2:0] op, input logic first,
                                     input logic [23:0] ln, input logic [15:0] col,
                                     input logic [15:0] len, input logic [7:0] data,
                                     input logic [5:0] idx, input logic [11:0] off,
                                     input logic [15:0] lim);
    in_item_t it;
    it = '{op, first, ln, col, len, data, idx, off, lim};
    return it;
  endfunction

  function automatic out_item_t mk_res(input status_e st, input logic kind,
                                       input logic [23:0] ln, input logic [15:0] col,
                                       input logic [15:0] len, input logic [11:0] pos,
                                       input logic [7:0] data, input logic [6:0] cnt,
                                       input logic [12:0] used);
    out_item_t r;
    r = '{st, kind, ln, col, len, pos, data, cnt, used};
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.opcode = OP_INSERT;
    it.first = 1'($urandom_range(0, 1));
    it.line = 24'($urandom_range(0, 24'hFFFFFF));
    it.column = 16'($urandom_range(0, 16'hFFFF));
    it.length = 16'($urandom_range(0, 16'hFFFF));
    it.data_byte = 8'($urandom_range(0, 8'hFF));
    it.record_index = 6'($urandom_range(0, 63));
    it.byte_offset = 12'($urandom_range(0, 12'hFFF));
    it.limit = 16'($urandom_range(0, 16'hFFFF));
    return it;
  endfunction

  function automatic in_item_t text_read(input in_item_t base);
    in_item_t    it;
    int unsigned held [$];
    int unsigned i;
    int unsigned len;
    int unsigned pick;
    it = base;
    it.opcode = OP_READ_TEXT;
    for (i = 0; i < rec_fill; i++)
      if (kind_at[(rec_head + i) % MAX_RECORDS]) held.push_back(i);
    if (held.size() == 0 || $urandom_range(0, 9) == 0) return it;
    i = held[$urandom_range(0, held.size() - 1)];
    len = len_at[(rec_head + i) % MAX_RECORDS];
    it.record_index = 6'(i);
    it.byte_offset = 12'($urandom_range(0, len - 1));
    it.limit = 16'($urandom_range(len, 16'hFFFF));
    pick = $urandom_range(0, 9);
    if (pick == 0) it.limit = 16'($urandom_range(0, len - 1));
    if (pick == 1 && len < TEXT_SIZE) it.byte_offset = 12'($urandom_range(len, TEXT_SIZE - 1));
    return it;
  endfunction

  function automatic in_item_t next_edit();
    in_item_t    it;
    int unsigned r;
    it = rand_item();
    if (del_left > 0 && $urandom_range(0, 99) < 85) begin
      it.opcode = OP_DEL_BYTE;
      it.first = 1'b0;
      del_left--;
      return it;
    end
    r = $urandom_range(0, 999);
    if (r < 330) begin
      it.opcode = OP_DEL_BYTE;
      it.first = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 75) it.length = 16'($urandom_range(1, 6));
      else if (r < 95) it.length = 16'($urandom_range(7, 40));
      else it.length = 16'($urandom_range(41, 300));
      del_left = int'(it.length) - 1;
    end else if (r < 480) begin
      r = $urandom_range(0, 9);
      if (r == 0) it.length = '0;
      else if (r == 1) it.length = 16'($urandom_range(1, 4));
      else it.length = 16'($urandom_range(1, 16'hFFFF));
      del_left = 0;
    end else if (r < 680) begin
      it.opcode = OP_READ_REC;
      if (rec_fill > 0 && $urandom_range(0, 9) != 0)
        it.record_index = 6'($urandom_range(0, rec_fill - 1));
    end else if (r < 900) begin
      it = text_read(it);
    end else if (r < 930) begin
      it.opcode = OP_DEL_BYTE;
      it.first = 1'b1;
      it.length = '0;
    end else if (r < 955) begin
      it.opcode = OP_DEL_BYTE;
      it.first = 1'b0;
    end else if (r < 975) begin
      it.opcode = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    end else if (r < 978) begin
      it.opcode = OP_DEL_BYTE;
      it.first = 1'b1;
      it.length = 16'($urandom_range(TEXT_SIZE + 1, 16'hFFFF));
      del_left = 0;
    end else if (r < 981) begin
      it.opcode = OP_CLEAR;
      del_left = 0;
    end else begin
      it.opcode = OP_READ_REC;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res,
                           output out_item_t pred);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_data_i = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = log_edit(it);
    result_q.push_back(typed ? typed_res : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_recording(input bit on);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = on;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    rec_on = on;
    n_cfg++;
  endtask

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $display("%0t: result with none outstanding, expected nothing, actual %h",
                 $time, out_data_o);
        n_fail++;
      end else begin
        want_res = result_q.pop_front();
        compare_field("status", want_res.status, out_data_o.status);
        compare_field("rec_kind", want_res.rec_kind, out_data_o.rec_kind);
        compare_field("rec_line", want_res.rec_line, out_data_o.rec_line);
        compare_field("rec_column", want_res.rec_column, out_data_o.rec_column);
        compare_field("rec_length", want_res.rec_length, out_data_o.rec_length);
        compare_field("rec_text_pos", want_res.rec_text_pos, out_data_o.rec_text_pos);
        compare_field("read_byte", want_res.read_byte, out_data_o.read_byte);
        compare_field("record_count", want_res.record_count, out_data_o.record_count);
        compare_field("text_used", want_res.text_used, out_data_o.text_used);
        n_checked++;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold_left = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL edit_history_ring_log_unit");
    $finish;
  end

  initial begin
    in_item_t    it;
    out_item_t   pred;
    int unsigned ph;
    int unsigned k;
    int unsigned counted;
    int unsigned i;
    int unsigned j;
    int unsigned wrap_len [3];

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b1;
    wrap_len = '{200, 150, 100};

    dir_rows.push_back('{mk_in(OP_READ_REC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_REFUSED, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_in(OP_READ_TEXT, 0, 0, 0, 0, 0, 6'h3F, 12'hFFF, 16'hFFFF), 1'b1,
                         mk_res(ST_REFUSED, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_in(OP_INSERT, 0, 24'hFFFFFF, 16'hFFFF, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_IGNORED, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_in(OP_INSERT, 0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mk_in(OP_READ_REC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1, 0)});
    dir_rows.push_back('{mk_in(OP_READ_TEXT, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
                         mk_res(ST_REFUSED, 0, 0, 0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 1, 0, 0, 3, 8'hAA, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 0, 0, 0, 0, 8'h55, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mk_in(OP_INSERT, 0, 1, 1, 1, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 2, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 0, 0, 0, 0, 8'h33, 0, 0, 0), 1'b1,
                         mk_res(ST_IGNORED, 0, 0, 0, 0, 0, 0, 2, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 1, 24'h123456, 16'hABCD, 2, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 2, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 1, 24'hABCDEF, 16'h1234, 2, 8'h11, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 2, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 0, 0, 0, 0, 8'hFF, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 3, 2)});
    dir_rows.push_back('{mk_in(OP_READ_REC, 0, 0, 0, 0, 0, 2, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_in(OP_READ_TEXT, 0, 0, 0, 0, 0, 2, 1, 2), 1'b0, '0});
    dir_rows.push_back('{mk_in(OP_READ_TEXT, 0, 0, 0, 0, 0, 2, 2, 2), 1'b0, '0});
    dir_rows.push_back('{mk_in(OP_READ_TEXT, 0, 0, 0, 0, 0, 2, 0, 1), 1'b0, '0});
    dir_rows.push_back('{mk_in(OP_READ_REC, 0, 0, 0, 0, 0, 3, 0, 0), 1'b1,
                         mk_res(ST_REFUSED, 0, 0, 0, 0, 0, 0, 3, 2)});
    for (i = OP_RSVD_LO; i <= OP_RSVD_HI; i++)
      dir_rows.push_back('{mk_in(3'(i), 1, 0, 0, 1, 0, 0, 0, 0), 1'b1,
                           mk_res(ST_IGNORED, 0, 0, 0, 0, 0, 0, 3, 2)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 1, 0, 0, TEXT_SIZE + 1, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_CLEARED, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 0, 0, 0, 0, 8'h01, 0, 0, 0), 1'b1,
                         mk_res(ST_IGNORED, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 1, 0, 0, 16'hFFFF, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_CLEARED, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_in(OP_INSERT, 0, 2, 2, 5, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mk_in(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_in(OP_DEL_BYTE, 1, 0, 0, 1, 8'h80, 0, 0, 0), 1'b1,
                         mk_res(ST_DONE, 0, 0, 0, 0, 0, 0, 1, 1)});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res, pred);

    // hold a deletion open across a recording-off window
    it = rand_item();
    it.opcode = OP_DEL_BYTE;
    it.first = 1'b1;
    it.length = 16'd3;
    send_item(it, 1'b0, '0, pred);
    write_recording(1'b0);
    it = rand_item();
    it.opcode = OP_DEL_BYTE;
    it.first = 1'b0;
    send_item(it, 1'b0, '0, pred);
    it = rand_item();
    it.length = 16'd7;
    send_item(it, 1'b0, '0, pred);
    it = rand_item();
    it.opcode = OP_DEL_BYTE;
    it.first = 1'b1;
    it.length = 16'd16;
    send_item(it, 1'b0, '0, pred);
    it = rand_item();
    it.opcode = OP_READ_REC;
    it.record_index = '0;
    send_item(it, 1'b0, '0, pred);
    write_recording(1'b1);
    for (i = 0; i < 2; i++) begin
      it = rand_item();
      it.opcode = OP_DEL_BYTE;
      it.first = 1'b0;
      send_item(it, 1'b0, '0, pred);
    end
    send_item(text_read(rand_item()), 1'b0, '0, pred);

    // stream a few long deletions back to back, then read their text
    send_item(mk_in(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0, pred);
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < wrap_len[i]; j++) begin
        it = rand_item();
        it.opcode = OP_DEL_BYTE;
        it.first = (j == 0);
        it.length = 16'(wrap_len[i]);
        send_item(it, 1'b0, '0, pred);
      end
    end
    for (i = 0; i < 20; i++) send_item(text_read(rand_item()), 1'b0, '0, pred);
    del_left = 0;

    for (ph = 0; ph < 6; ph++) begin
      write_recording(PHASE_REC_ON[ph]);
      idle_on = PHASE_IDLE[ph];
      counted = 0;
      k = 0;
      while (counted < phase_items[ph]) begin
        if (ph == 0 && k == 100) long_hold_req = 1'b1;
        if (ph == 3 && k == 150) wait_drained();
        send_item(next_edit(), 1'b0, '0, pred);
        counted++;
        k++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Run: %0d transactions sent, %0d results checked, %0d recording writes.",
             n_sent, n_checked, n_cfg);
    $display("Covered record eviction, long, oversized and abandoned deletions, and stalls.");
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("PASS edit_history_ring_log_unit");
    end else begin
      $display("FAIL edit_history_ring_log_unit");
    end
    $finish;
  end

endmodule

### sim.f
design/ehrl_pkg.sv
design/ehrl_ram.sv
design/ehrl_ring_ctl.sv
design/edit_history_ring_log_unit.sv
tb/edit_history_ring_log_unit_tb.sv
